// ===== hdl/hvr_pkg.sv =====
// Shared types and constants for the heater valve regulator.
// No dependencies; used by hvr_div and heater_valve_regulator_top.

package hvr_pkg;

  // Shared divider: unsigned magnitude dividend and divisor widths
  localparam int DVD_W  = 34;
  localparam int DVS_W  = 15;
  localparam int DIV_ITER = DVD_W / 2;   // two quotient bits per cycle
  localparam int CNT_W  = $clog2(DIV_ITER);

  // Shared multiplier and angle accumulator widths
  localparam int MUL_W  = 19;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 24;

  // Fixed scale factors and hysteresis bands
  localparam int SCALE_MILLI = 1000;
  localparam logic [DVS_W-1:0] DIV_MILLI = 15'd1000;
  localparam logic [DVS_W-1:0] DIV_CENTI = 15'd100;
  localparam logic signed [16:0] BAND_HEAT = 17'sd200;
  localparam logic signed [16:0] BAND_COOL = 17'sd250;
  localparam logic signed [16:0] BAND_FAR  = 17'sd500;

  // Coil indicator codes
  typedef enum logic [1:0] {
    IND_NONE  = 2'd0,
    IND_STEADY = 2'd1,
    IND_BLINK = 2'd2
  } coil_ind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WINTER_MODE  = 3'd0,
    CFG_GAIN         = 3'd1,
    CFG_VALVE_LOW    = 3'd2,
    CFG_VALVE_HIGH   = 3'd3,
    CFG_DEAD_BAND    = 3'd4,
    CFG_INTEG_TICKS  = 3'd5,
    CFG_STOP_TARGET  = 3'd6,
    CFG_OUTDOOR_MIN  = 3'd7
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_KW,
    ST_FMUL,
    ST_FDIV,
    ST_FW,
    ST_BRANCH,
    ST_CMUL,
    ST_CDIV,
    ST_CW,
    ST_SMUL,
    ST_SDIV,
    ST_SW,
    ST_RCHK,
    ST_EW,
    ST_STOP1,
    ST_STOP2,
    ST_STOP3,
    ST_STOP4,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/heater_valve_regulator_top.sv =====
// Heater valve regulator: one tick per input transaction, sequenced over a
// shared multiplier and the shared divider hvr_div. Depends on hvr_pkg, hvr_div.
// A proportional update takes up to four divider passes; the floor slope and floor
// passes run only when outdoor is below the no-limit temperature. s_tready_o is
// low until the result is loaded, so a new tick is taken only after the last one
// has been handed on. Reset (async, active low) loads register defaults,
// angle = 50, timers 0.

module heater_valve_regulator_top #(
  parameter int NO_LIMIT_TEMP   = 1000,
  parameter int FLOOR_SPAN      = 100,
  parameter int STOP_HOLD_TICKS = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input ticks
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // [14:0] setpoint_temp, [29:15] room_temp, [44:30] outdoor_temp,
  // [59:45] water_out_temp, [74:60] water_in_temp, [79:75] zero
  input  logic [79:0] s_tdata_i,
  // [0] unit_stopped
  input  logic        s_tuser_i,
  // Results
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [7:0] valve_angle, [8] pump_on, [10:9] coil_indicator, [11] regulated,
  // [15:12] zero
  output logic [15:0] m_tdata_o,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int ACC_W = hvr_pkg::ACC_W;
  localparam logic [hvr_pkg::DVD_W-1:0] K_NUM =
    hvr_pkg::DVD_W'(FLOOR_SPAN * hvr_pkg::SCALE_MILLI);
  localparam logic signed [16:0] NL_TEMP = 17'(NO_LIMIT_TEMP);
  localparam logic [15:0] HOLD_TICKS = 16'(STOP_HOLD_TICKS);

  // Range check: raise to valve_low, then floor, else cap at valve_high
  function automatic logic [7:0] check_range(input logic signed [ACC_W-1:0] a,
                                             input logic [7:0] fl,
                                             input logic [7:0] vl,
                                             input logic [7:0] vh);
    logic signed [ACC_W-1:0] b;
    logic [7:0]              r;
    b = (a <= $signed({{(ACC_W-8){1'b0}}, vl})) ? $signed({{(ACC_W-8){1'b0}}, vl}) : a;
    if (b < $signed({{(ACC_W-8){1'b0}}, fl})) begin
      r = fl;
    end else if (b >= $signed({{(ACC_W-8){1'b0}}, vh})) begin
      r = vh;
    end else begin
      r = b[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] sat8(input logic signed [ACC_W-1:0] a);
    logic [7:0] r;
    if (a < 0) begin
      r = 8'd0;
    end else if (a > $signed(ACC_W'(255))) begin
      r = 8'd255;
    end else begin
      r = a[7:0];
    end
    return r;
  endfunction

  // Control and configuration registers
  hvr_pkg::state_e state_q, state_d;
  logic        winter_q;
  logic [13:0] gain_q;
  logic [7:0]  vlow_q;
  logic [7:0]  vhigh_q;
  logic [14:0] dead_band_q;
  logic [15:0] integ_ticks_q;
  logic signed [14:0] stop_target_q;
  logic signed [13:0] outdoor_min_q;
  logic [7:0]  angle_q, angle_d;
  logic        pump_q, pump_d;
  logic [15:0] period_q, period_d;
  logic [15:0] stop_q, stop_d;
  logic        m_valid_q, m_valid_d;

  // Datapath registers
  logic signed [14:0] set_q, room_q, outdoor_q, wout_q, win_q;
  logic        stopped_q;
  logic [17:0] k_q, k_d;
  logic signed [hvr_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [7:0]  floor_q, floor_d;
  logic signed [13:0] coef_q, coef_d;
  logic signed [9:0]  estop_q, estop_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [1:0]  ind_q, ind_d;
  logic        reg_q, reg_d;
  logic [15:0] m_data_q, m_data_d;

  // Shared units
  logic signed [hvr_pkg::MUL_W-1:0] mul_a, mul_b;
  logic                        div_start;
  logic [hvr_pkg::DVD_W-1:0]   div_dvd;
  logic [hvr_pkg::DVS_W-1:0]   div_dvs;
  logic                        div_done;
  logic [hvr_pkg::DVD_W-1:0]   div_quot;

  // Derived values
  logic                     accept;
  logic [13:0]              omin_abs;
  logic [14:0]              lim;
  logic signed [16:0]       out17, wout17, tgt17, nl_diff;
  logic signed [15:0]       err, tw_diff;
  logic [15:0]              err_mag;
  logic                     cold, in_range, st_zero;
  logic                     c_heat, c_cool, c_far, c_deep;
  logic signed [8:0]        span;
  logic [hvr_pkg::PROD_W-1:0] prod_abs;
  logic [8:0]               floor_sum;
  logic [ACC_W-1:0]         step_mag;
  logic [13:0]              coef_mag;
  logic [9:0]               estop_mag;

  assign accept     = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == hvr_pkg::ST_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  assign omin_abs = outdoor_min_q[13] ? 14'(-outdoor_min_q) : 14'(outdoor_min_q);
  assign lim      = {1'b0, omin_abs} + 15'(NO_LIMIT_TEMP);
  assign out17    = 17'(outdoor_q);
  assign wout17   = 17'(wout_q);
  assign tgt17    = 17'(stop_target_q);
  assign nl_diff  = NL_TEMP - out17;
  assign cold     = out17 < NL_TEMP;
  assign err      = 16'(set_q) - 16'(room_q);
  assign err_mag  = err[15] ? 16'(-err) : 16'(err);
  assign tw_diff  = 16'(stop_target_q) - 16'(wout_q);
  assign in_range = (angle_q >= vlow_q) && (angle_q <= vhigh_q);
  assign st_zero  = (stop_q == 16'd0);
  assign c_heat   = (wout17 <= tgt17 - hvr_pkg::BAND_HEAT) && st_zero;
  assign c_cool   = (wout17 > tgt17 + hvr_pkg::BAND_COOL) && st_zero;
  assign c_far    = wout17 >= tgt17 + hvr_pkg::BAND_FAR;
  assign c_deep   = wout17 < tgt17 - hvr_pkg::BAND_FAR;
  assign span     = $signed({1'b0, vhigh_q}) - $signed({1'b0, vlow_q});
  assign prod_abs = prod_q[hvr_pkg::PROD_W-1] ? hvr_pkg::PROD_W'(-prod_q)
                                              : hvr_pkg::PROD_W'(prod_q);
  assign floor_sum = {1'b0, vlow_q} + {1'b0, div_quot[7:0]};
  assign step_mag  = {1'b0, div_quot[ACC_W-2:0]};
  assign coef_mag  = {1'b0, div_quot[12:0]};
  assign estop_mag = {1'b0, div_quot[8:0]};

  hvr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      hvr_pkg::ST_FMUL: begin
        mul_a = hvr_pkg::MUL_W'(nl_diff);
        mul_b = $signed({1'b0, k_q});
      end
      hvr_pkg::ST_CMUL: begin
        mul_a = $signed({5'b0, gain_q});
        mul_b = hvr_pkg::MUL_W'(span);
      end
      hvr_pkg::ST_SMUL: begin
        mul_a = hvr_pkg::MUL_W'(err);
        mul_b = hvr_pkg::MUL_W'(coef_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d   = state_q;
    angle_d   = angle_q;
    pump_d    = pump_q;
    period_d  = period_q;
    stop_d    = stop_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    k_d       = k_q;
    prod_d    = prod_q;
    floor_d   = floor_q;
    coef_d    = coef_q;
    estop_d   = estop_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    ind_d     = ind_q;
    reg_d     = reg_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;

    if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      hvr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = hvr_pkg::ST_PREP;
        end
      end

      // Timer decrement and choice of path
      hvr_pkg::ST_PREP: begin
        ind_d = hvr_pkg::IND_NONE;
        reg_d = 1'b0;
        if (!winter_q) begin
          state_d = hvr_pkg::ST_DONE;
        end else begin
          period_d = period_q - 16'(period_q != 16'd0);
          stop_d   = stop_q - 16'(stop_q != 16'd0);
          if (!stopped_q && period_d != 16'd0) begin
            state_d = hvr_pkg::ST_DONE;
          end else if (!cold) begin
            floor_d = 8'd0;
            state_d = hvr_pkg::ST_BRANCH;
          end else if (lim == '0) begin
            k_d     = '0;
            state_d = hvr_pkg::ST_FMUL;
          end else begin
            div_start = 1'b1;
            div_dvd   = K_NUM;
            div_dvs   = lim;
            state_d   = hvr_pkg::ST_KW;
          end
        end
      end

      // Floor slope k
      hvr_pkg::ST_KW: begin
        if (div_done) begin
          k_d     = div_quot[17:0];
          state_d = hvr_pkg::ST_FMUL;
        end
      end

      hvr_pkg::ST_FMUL: begin
        prod_d  = mul_a * mul_b;
        state_d = hvr_pkg::ST_FDIV;
      end

      hvr_pkg::ST_FDIV: begin
        div_start = 1'b1;
        div_dvd   = prod_abs[hvr_pkg::DVD_W-1:0];
        div_dvs   = hvr_pkg::DIV_MILLI;
        state_d   = hvr_pkg::ST_FW;
      end

      // Floor saturates at full scale
      hvr_pkg::ST_FW: begin
        if (div_done) begin
          floor_d = (|div_quot[hvr_pkg::DVD_W-1:8] || floor_sum[8]) ? 8'd255
                                                                     : floor_sum[7:0];
          state_d = hvr_pkg::ST_BRANCH;
        end
      end

      hvr_pkg::ST_BRANCH: begin
        if (stopped_q) begin
          div_start = 1'b1;
          div_dvd   = hvr_pkg::DVD_W'(tw_diff[15] ? 16'(-tw_diff) : 16'(tw_diff));
          div_dvs   = hvr_pkg::DIV_CENTI;
          neg_d     = tw_diff[15];
          state_d   = hvr_pkg::ST_EW;
        end else begin
          reg_d = 1'b1;
          if (err_mag > {1'b0, dead_band_q} && in_range) begin
            state_d = hvr_pkg::ST_CMUL;
          end else begin
            acc_d   = ACC_W'(angle_q);
            state_d = hvr_pkg::ST_RCHK;
          end
        end
      end

      // Step coefficient gain * span / 1000
      hvr_pkg::ST_CMUL: begin
        prod_d  = mul_a * mul_b;
        state_d = hvr_pkg::ST_CDIV;
      end

      hvr_pkg::ST_CDIV: begin
        div_start = 1'b1;
        div_dvd   = prod_abs[hvr_pkg::DVD_W-1:0];
        div_dvs   = hvr_pkg::DIV_MILLI;
        neg_d     = prod_q[hvr_pkg::PROD_W-1];
        state_d   = hvr_pkg::ST_CW;
      end

      hvr_pkg::ST_CW: begin
        if (div_done) begin
          coef_d  = neg_q ? $signed(-coef_mag) : $signed(coef_mag);
          state_d = hvr_pkg::ST_SMUL;
        end
      end

      // Proportional step err * coef / 100
      hvr_pkg::ST_SMUL: begin
        prod_d  = mul_a * mul_b;
        state_d = hvr_pkg::ST_SDIV;
      end

      hvr_pkg::ST_SDIV: begin
        div_start = 1'b1;
        div_dvd   = prod_abs[hvr_pkg::DVD_W-1:0];
        div_dvs   = hvr_pkg::DIV_CENTI;
        neg_d     = prod_q[hvr_pkg::PROD_W-1];
        state_d   = hvr_pkg::ST_SW;
      end

      hvr_pkg::ST_SW: begin
        if (div_done) begin
          acc_d   = $signed(ACC_W'(angle_q)) + (neg_q ? $signed(-step_mag)
                                                      : $signed(step_mag));
          state_d = hvr_pkg::ST_RCHK;
        end
      end

      // End of a proportional period
      hvr_pkg::ST_RCHK: begin
        angle_d  = check_range(acc_q, floor_q, vlow_q, vhigh_q);
        period_d = integ_ticks_q;
        state_d  = hvr_pkg::ST_DONE;
      end

      // Stop-mode correction (target - return) / 100
      hvr_pkg::ST_EW: begin
        if (div_done) begin
          estop_d = neg_q ? $signed(-estop_mag) : $signed(estop_mag);
          state_d = hvr_pkg::ST_STOP1;
        end
      end

      hvr_pkg::ST_STOP1: begin
        acc_d   = ACC_W'(check_range(ACC_W'(angle_q), floor_q, vlow_q, vhigh_q));
        state_d = hvr_pkg::ST_STOP2;
      end

      hvr_pkg::ST_STOP2: begin
        if (c_heat) begin
          acc_d = acc_q + ACC_W'(estop_q);
        end else if (c_cool) begin
          acc_d = ACC_W'(check_range(acc_q, floor_q, vlow_q, vhigh_q));
        end
        state_d = hvr_pkg::ST_STOP3;
      end

      hvr_pkg::ST_STOP3: begin
        if (c_heat) begin
          acc_d = ACC_W'(check_range(acc_q, floor_q, vlow_q, vhigh_q));
        end else if (c_cool && c_far) begin
          acc_d = acc_q + ACC_W'(estop_q);
        end
        state_d = hvr_pkg::ST_STOP4;
      end

      // Pump, indicator and hold timer
      hvr_pkg::ST_STOP4: begin
        angle_d = sat8(acc_q);
        if (c_heat) begin
          stop_d = HOLD_TICKS;
          if (c_deep) begin
            ind_d  = hvr_pkg::IND_BLINK;
            pump_d = 1'b1;
          end else begin
            ind_d  = hvr_pkg::IND_STEADY;
            pump_d = 1'b0;
          end
        end else if (c_cool) begin
          stop_d = HOLD_TICKS;
          if (pump_q) begin
            ind_d  = hvr_pkg::IND_STEADY;
            pump_d = 1'b0;
          end
        end else if (st_zero) begin
          stop_d = HOLD_TICKS;
          if (win_q >= stop_target_q) begin
            pump_d = 1'b0;
          end
        end
        state_d = hvr_pkg::ST_DONE;
      end

      // Hand the result to the output register
      hvr_pkg::ST_DONE: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'b0, reg_q, ind_q, pump_q, angle_q};
          state_d   = hvr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = hvr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= hvr_pkg::ST_IDLE;
      winter_q      <= 1'b1;
      gain_q        <= 14'd100;
      vlow_q        <= 8'd50;
      vhigh_q       <= 8'd250;
      dead_band_q   <= 15'd100;
      integ_ticks_q <= 16'd10;
      stop_target_q <= 15'sd2500;
      outdoor_min_q <= -14'sd3000;
      angle_q       <= 8'd50;
      pump_q        <= 1'b0;
      period_q      <= 16'd0;
      stop_q        <= 16'd0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      angle_q   <= angle_d;
      pump_q    <= pump_d;
      period_q  <= period_d;
      stop_q    <= stop_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (hvr_pkg::cfg_idx_e'(cfg_addr_i))
          hvr_pkg::CFG_WINTER_MODE: winter_q      <= cfg_wdata_i[0];
          hvr_pkg::CFG_GAIN:        gain_q        <= cfg_wdata_i[13:0];
          hvr_pkg::CFG_VALVE_LOW:   vlow_q        <= cfg_wdata_i[7:0];
          hvr_pkg::CFG_VALVE_HIGH:  vhigh_q       <= cfg_wdata_i[7:0];
          hvr_pkg::CFG_DEAD_BAND:   dead_band_q   <= cfg_wdata_i[14:0];
          hvr_pkg::CFG_INTEG_TICKS: integ_ticks_q <= cfg_wdata_i;
          hvr_pkg::CFG_STOP_TARGET: stop_target_q <= cfg_wdata_i[14:0];
          hvr_pkg::CFG_OUTDOOR_MIN: outdoor_min_q <= cfg_wdata_i[13:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q     <= s_tdata_i[14:0];
      room_q    <= s_tdata_i[29:15];
      outdoor_q <= s_tdata_i[44:30];
      wout_q    <= s_tdata_i[59:45];
      win_q     <= s_tdata_i[74:60];
      stopped_q <= s_tuser_i;
    end
    k_q      <= k_d;
    prod_q   <= prod_d;
    floor_q  <= floor_d;
    coef_q   <= coef_d;
    estop_q  <= estop_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    ind_q    <= ind_d;
    reg_q    <= reg_d;
    m_data_q <= m_data_d;
  end

endmodule

// ===== hdl/hvr_div.sv =====
// Shared iterative unsigned divider, two quotient bits per cycle.
// Depends on hvr_pkg for operand widths and iteration count.

module hvr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hvr_pkg::DVD_W-1:0]  dividend_i,
  input  logic [hvr_pkg::DVS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [hvr_pkg::DVD_W-1:0]  quotient_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [hvr_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [hvr_pkg::DVS_W-1:0]   rem_q, rem_d;
  logic [hvr_pkg::DVD_W-1:0]   quo_q, quo_d;
  logic [hvr_pkg::DVS_W-1:0]   dvs_q, dvs_d;

  logic [hvr_pkg::DVS_W-1:0]   rem_v;
  logic [hvr_pkg::DVD_W-1:0]   quo_v;
  logic [hvr_pkg::DVS_W:0]     trial;

  // Two restoring steps per cycle
  always_comb begin
    rem_v = rem_q;
    quo_v = quo_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_v, quo_v[hvr_pkg::DVD_W-1]};
      quo_v = {quo_v[hvr_pkg::DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_v[0] = 1'b1;
      end
      rem_v = trial[hvr_pkg::DVS_W-1:0];
    end
  end

  // Sequencing of one division
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = hvr_pkg::CNT_W'(hvr_pkg::DIV_ITER - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = rem_v;
      quo_d = quo_v;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== bench/heater_valve_regulator_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for heater_valve_regulator_top: random and directed ticks
// checked against a cycle-free valve model. Depends on hvr_pkg and the RTL.

module heater_valve_regulator_top_test;

  localparam int NO_LIMIT_TEMP   = 1000;
  localparam int FLOOR_SPAN      = 100;
  localparam int STOP_HOLD_TICKS = 60;
  localparam int STALL_LIMIT     = 4000;
  localparam int REPORT_MAX      = 10;

  // One sensor tick
  typedef struct {
    logic signed [14:0] setpoint, room, outdoor, water_out, water_in;
    logic               stopped;
  } tick_t;

  // One valve command
  typedef struct {
    logic [7:0]         angle;
    logic               pump;
    hvr_pkg::coil_ind_e coil;
    logic               regulated;
  } valve_cmd_t;

  // Valve model: register copies, regulator state and the commands still owed
  class valve_scoreboard;
    bit         winter_on;
    longint     gain, valve_low, valve_high, dead_band, integ_ticks;
    longint     stop_target, outdoor_min;
    longint     angle, period_timer, stop_timer;
    bit         pump;
    valve_cmd_t pending_cmds[$];
    int         mismatches;

    function new();
      winter_on    = 1'b1;
      gain         = 100;
      valve_low    = 50;
      valve_high   = 250;
      dead_band    = 100;
      integ_ticks  = 10;
      stop_target  = 2500;
      outdoor_min  = -3000;
      angle        = 50;
      pump         = 1'b0;
      period_timer = 0;
      stop_timer   = 0;
      mismatches   = 0;
    endfunction

    function void set_register(hvr_pkg::cfg_idx_e idx, logic [15:0] v);
      case (idx)
        hvr_pkg::CFG_WINTER_MODE: winter_on   = v[0];
        hvr_pkg::CFG_GAIN:        gain        = longint'(v[13:0]);
        hvr_pkg::CFG_VALVE_LOW:   valve_low   = longint'(v[7:0]);
        hvr_pkg::CFG_VALVE_HIGH:  valve_high  = longint'(v[7:0]);
        hvr_pkg::CFG_DEAD_BAND:   dead_band   = longint'(v[14:0]);
        hvr_pkg::CFG_INTEG_TICKS: integ_ticks = longint'(v[15:0]);
        hvr_pkg::CFG_STOP_TARGET: stop_target = longint'($signed(v[14:0]));
        hvr_pkg::CFG_OUTDOOR_MIN: outdoor_min = longint'($signed(v[13:0]));
        default: ;
      endcase
    endfunction

    // Raise to valve_low, then apply the outdoor floor or the upper limit
    function longint limit_angle(longint a, longint outdoor);
      longint span, slope, flr;
      span  = (outdoor_min < 0 ? -outdoor_min : outdoor_min) + NO_LIMIT_TEMP;
      slope = (span != 0) ? (FLOOR_SPAN * 1000) / span : 0;
      flr   = 0;
      if (outdoor < NO_LIMIT_TEMP) begin
        flr = valve_low + ((NO_LIMIT_TEMP - outdoor) * slope) / 1000;
        if (flr > 255) flr = 255;
        if (flr < 0) flr = 0;
      end
      if (a <= valve_low) a = valve_low;
      if (a < flr) a = flr;
      else if (a >= valve_high) a = valve_high;
      return a;
    endfunction

    // Advance the regulator by one accepted tick and queue its command
    function void note_tick(tick_t t);
      longint     a, err, mag, coef, tgt, estop, wout, win, outd;
      valve_cmd_t cmd;
      cmd.coil      = hvr_pkg::IND_NONE;
      cmd.regulated = 1'b0;
      wout = longint'(t.water_out);
      win  = longint'(t.water_in);
      outd = longint'(t.outdoor);
      if (winter_on) begin
        a = angle;
        if (period_timer != 0) period_timer--;
        if (stop_timer != 0) stop_timer--;
        if (!t.stopped) begin
          if (period_timer == 0) begin
            err = longint'(t.setpoint) - longint'(t.room);
            mag = err < 0 ? -err : err;
            if (mag > dead_band && a >= valve_low && a <= valve_high) begin
              coef = (gain * (valve_high - valve_low)) / 1000;
              a += (err * coef) / 100;
            end
            a = limit_angle(a, outd);
            period_timer  = integ_ticks;
            cmd.regulated = 1'b1;
          end
        end else begin
          tgt   = stop_target;
          estop = (tgt - wout) / 100;
          a = limit_angle(a, outd);
          // heating band
          if (wout <= tgt - 200 && stop_timer == 0) begin
            stop_timer = longint'(STOP_HOLD_TICKS);
            a = limit_angle(a + estop, outd);
            if (wout < tgt - 500) begin
              cmd.coil = hvr_pkg::IND_BLINK;
              pump     = 1'b1;
            end else begin
              cmd.coil = hvr_pkg::IND_STEADY;
              pump     = 1'b0;
            end
          end
          // cooling band, no range check after the step
          if (wout > tgt + 250 && stop_timer == 0) begin
            stop_timer = longint'(STOP_HOLD_TICKS);
            a = limit_angle(a, outd);
            if (pump) begin
              cmd.coil = hvr_pkg::IND_STEADY;
              pump     = 1'b0;
            end
            if (wout >= tgt + 500) a += estop;
          end
          // between the bands: release the pump on warm supply
          if (stop_timer == 0) begin
            stop_timer = longint'(STOP_HOLD_TICKS);
            if (win >= tgt) pump = 1'b0;
          end
        end
        angle = (a < 0) ? 0 : (a > 255) ? 255 : a;
        period_timer &= 64'hFFFF;
        stop_timer   &= 64'hFFFF;
      end
      cmd.angle = angle[7:0];
      cmd.pump  = pump;
      pending_cmds.push_back(cmd);
    endfunction

    // Compare one result transaction with the oldest command owed
    function void check_result(logic [15:0] d);
      valve_cmd_t want, got;
      got.angle     = d[7:0];
      got.pump      = d[8];
      got.coil      = hvr_pkg::coil_ind_e'(d[10:9]);
      got.regulated = d[11];
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("unexpected result transaction %h", d);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.angle !== want.angle || got.pump !== want.pump ||
          got.coil !== want.coil || got.regulated !== want.regulated) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: angle %0d/%0d pump %0b/%0b coil %0d/%0d reg %0b/%0b (exp/act)",
                   want.angle, got.angle, want.pump, got.pump, want.coil, got.coil,
                   want.regulated, got.regulated);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [79:0] s_tdata_i;
  logic        s_tuser_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [15:0] m_tdata_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;

  valve_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;
  bit stop_run;

  heater_valve_regulator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: check accepted transactions, then redraw tready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o);
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic tick_t make_tick(int sp, int room, int outd, int wout, int win,
                                      bit stopped);
    tick_t t;
    t.setpoint  = 15'(sp);
    t.room      = 15'(room);
    t.outdoor   = 15'(outd);
    t.water_out = 15'(wout);
    t.water_in  = 15'(win);
    t.stopped   = stopped;
    return t;
  endfunction

  // Mostly plausible temperatures around the setpoint and the water target,
  // with stop runs of random length and some full-range noise
  function tick_t random_tick();
    tick_t t;
    int    sp, tgt;
    if ($urandom_range(99) < 4) stop_run = !stop_run;
    t.stopped = stop_run ^ ($urandom_range(9) == 0);
    sp = ($urandom_range(99) < 70) ? pick(1500, 2600) : pick(-5000, 10000);
    t.setpoint = 15'(sp);
    t.room = 15'(($urandom_range(99) < 70) ? clip(sp + pick(-1500, 1500), -5000, 10000)
                                           : pick(-5000, 10000));
    t.outdoor = 15'(($urandom_range(99) < 30) ? pick(500, 1500) : pick(-5000, 10000));
    tgt = int'(sb.stop_target);
    t.water_out = 15'(($urandom_range(99) < 70) ? clip(tgt + pick(-900, 900), -5000, 15000)
                                                : pick(-5000, 15000));
    t.water_in = 15'(($urandom_range(99) < 50) ? clip(tgt + pick(-300, 300), -5000, 15000)
                                               : pick(-5000, 15000));
    return t;
  endfunction

  // Present one tick, with random idle cycles first
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {5'b0, t.water_in, t.water_out, t.outdoor, t.room, t.setpoint};
    s_tuser_i  <= t.stopped;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_tick(t);
  endtask

  task automatic wait_drained();
    while (sb.pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(hvr_pkg::cfg_idx_e idx, int value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= 16'(value);
    sb.set_register(idx, 16'(value));
    @(posedge clk_i);
  endtask

  task automatic program_regs(int winter, int gain, int vlow, int vhigh, int dband,
                              int iticks, int target, int omin);
    write_reg(hvr_pkg::CFG_WINTER_MODE, winter);
    write_reg(hvr_pkg::CFG_GAIN, gain);
    write_reg(hvr_pkg::CFG_VALVE_LOW, vlow);
    write_reg(hvr_pkg::CFG_VALVE_HIGH, vhigh);
    write_reg(hvr_pkg::CFG_DEAD_BAND, dband);
    write_reg(hvr_pkg::CFG_INTEG_TICKS, iticks);
    write_reg(hvr_pkg::CFG_STOP_TARGET, target);
    write_reg(hvr_pkg::CFG_OUTDOOR_MIN, omin);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_ticks(int count);
    for (int i = 0; i < count; i++) send_tick(random_tick());
    s_tvalid_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    sb            = new();
    stop_run      = 1'b0;
    stall_cycles  = 0;
    send_idle_pct = 36;
    recv_idle_pct = 77;
    rst_ni        = 1'b0;
    s_tvalid_i    = 1'b0;
    s_tdata_i     = '0;
    s_tuser_i     = 1'b0;
    m_tready_i    = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = hvr_pkg::CFG_WINTER_MODE;
    cfg_wdata_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: regulate on every tick with the reset defaults otherwise
    write_reg(hvr_pkg::CFG_INTEG_TICKS, 0);
    cfg_we_i <= 1'b0;
    send_tick(make_tick(10000, -5000, 10000, 15000, 15000, 1'b0)); // largest positive error
    send_tick(make_tick(-5000, 10000, -5000, -5000, -5000, 1'b0)); // largest negative error
    send_tick(make_tick(2000, 1950, 500, 2500, 2500, 1'b0));      // inside dead band
    send_tick(make_tick(2000, 1900, 999, 2500, 2500, 1'b0));      // error equals dead band
    send_tick(make_tick(2000, 1899, 1000, 2500, 2500, 1'b0));     // just outside, floor off
    send_tick(make_tick(2100, 2000, 1001, 2500, 2500, 1'b0));
    send_tick(make_tick(-1, 0, -1, -1, -1, 1'b0));                // all-ones patterns
    send_tick(make_tick(5000, 2000, -3000, 2500, 2500, 1'b0));    // floor at design minimum
    send_tick(make_tick(2000, 5000, 9000, 2500, 2500, 1'b0));
    send_tick(make_tick(2000, 2000, 0, 1800, 2600, 1'b1));        // far below target: blink
    send_tick(make_tick(2000, 2000, 0, 2400, 2400, 1'b1));        // held by stop timer
    send_tick(make_tick(2000, 2000, 10000, 15000, -5000, 1'b1));
    send_tick(make_tick(2000, 2000, -5000, -5000, 15000, 1'b1));
    send_tick(make_tick(0, 10000, 0, 0, 0, 1'b0));
    send_tick(make_tick(10000, 0, 10000, 2500, 2500, 1'b0));
    s_tvalid_i <= 1'b0;
    wait_drained();

    // Receiver idles more than sender
    send_idle_pct = 36;
    recv_idle_pct = 77;
    program_regs(1, 100, 50, 250, 100, 2, 2500, -3000);
    run_ticks(250);
    program_regs(1, 10000, 0, 255, 0, 0, -5000, -5000);
    run_ticks(200);

    // Sender idles more than receiver
    send_idle_pct = 77;
    recv_idle_pct = 36;
    program_regs(0, 500, 40, 220, 10, 1, 2000, -2000);            // summer: all held
    run_ticks(60);
    program_regs(1, 0, 255, 0, 32767, 1, 10000, 0);               // inverted limits
    run_ticks(150);
    program_regs(1, pick(1, 10000), pick(0, 80), pick(150, 255), pick(0, 500),
                 pick(0, 4), pick(-5000, 10000), pick(-5000, 0));
    run_ticks(250);

    // No idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(1, 3000, 20, 240, 200, 65535, 0, -1000);         // longest period
    run_ticks(80);
    program_regs(1, pick(1, 10000), pick(10, 60), pick(180, 255), pick(0, 400),
                 pick(0, 3), pick(-1000, 5000), pick(-5000, 0));
    run_ticks(250);
    program_regs(1, 2500, 60, 200, 30, 1, 1500, -4000);
    run_ticks(60);

    repeat (150) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hvr_pkg.sv
hdl/hvr_div.sv
hdl/heater_valve_regulator_top.sv
bench/heater_valve_regulator_top_test.sv
